FILE: design/plc_timer_bank_bit_store_assert.svh
// Assertion macros for the timer bank RTL.
`ifndef PLC_TIMER_BANK_BIT_STORE_ASSERT_SVH
`define PLC_TIMER_BANK_BIT_STORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLC_ASSERT(lbl, clk, rst_n, prop)
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/plctmr_pkg.sv
package plctmr_pkg;

  localparam int NUM_TIMERS      = 32;
  localparam int NUM_OUTPUT_BITS = 16;
  localparam int NUM_MARKER_BITS = 64;
  localparam int NUM_INPUT_BITS  = 16;

  localparam int TMR_IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int OUT_IW = $clog2(NUM_OUTPUT_BITS);
  localparam int MRK_IW = (NUM_MARKER_BITS > 1) ? $clog2(NUM_MARKER_BITS) : 1;
  localparam int IN_IW  = $clog2(NUM_INPUT_BITS);

  localparam int IDX_W   = 6;
  localparam int CMP_W   = IDX_W + 1;
  localparam int CNT_W   = 15;
  localparam int BOUND_W = 6;
  localparam int PORT_W  = 8;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int DIVIDE_BY = 10;
  localparam int DIV_W     = 4;
  localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIVIDE_BY - 1);

  localparam logic [BOUND_W-1:0] FAST_END_RST = BOUND_W'(8);
  localparam logic [BOUND_W-1:0] MID_END_RST  = BOUND_W'(16);
  localparam logic [BOUND_W-1:0] SLOW_END_RST = BOUND_W'(32);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_END  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_END = 2'd2;

  // Raw operation and store codes on the stream.
  localparam logic [OP_W-1:0] OPC_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OPC_RUN   = 3'd1;
  localparam logic [OP_W-1:0] OPC_READ  = 3'd2;
  localparam logic [OP_W-1:0] OPC_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OPC_LOAD  = 3'd4;

  localparam logic [KIND_W-1:0] KC_X = 3'd0;
  localparam logic [KIND_W-1:0] KC_Y = 3'd1;
  localparam logic [KIND_W-1:0] KC_M = 3'd2;
  localparam logic [KIND_W-1:0] KC_T = 3'd3;

  // Stream packing.
  localparam int TD_IDX_LSB    = 0;
  localparam int TD_EN_LSB     = TD_IDX_LSB + IDX_W;
  localparam int TD_PRESET_LSB = TD_EN_LSB + 1;
  localparam int TD_WV_LSB     = TD_PRESET_LSB + CNT_W;
  localparam int TD_PORT_LSB   = TD_WV_LSB + 1;
  localparam int TD_IN_BITS    = TD_PORT_LSB + NUM_INPUT_BITS;
  localparam int TDATA_IN_W    = ((TD_IN_BITS + 7) / 8) * 8;
  localparam int TUSER_IN_W    = OP_W + KIND_W;
  localparam int TDATA_OUT_W   = ((1 + PORT_W + 7) / 8) * 8;

  localparam int QDEPTH = 2;
  localparam int Q_AW   = $clog2(QDEPTH);
  localparam int Q_CW   = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_TICK,
    OP_RUN,
    OP_READ,
    OP_WRITE,
    OP_LOAD,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    KIND_X,
    KIND_Y,
    KIND_M,
    KIND_T,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    op_e                       op;
    kind_e                     kind;
    logic [IDX_W-1:0]          idx;
    logic                      run_en;
    logic [CNT_W-1:0]          preset;
    logic                      wr_val;
    logic [NUM_INPUT_BITS-1:0] port;
  } cmd_t;

endpackage

FILE: design/plctmr_front.sv
module plctmr_front (
  input  logic [plctmr_pkg::TDATA_IN_W-1:0] tdata_i,
  input  logic [plctmr_pkg::TUSER_IN_W-1:0] tuser_i,
  output plctmr_pkg::cmd_t                  cmd_o
);

  logic [plctmr_pkg::OP_W-1:0]   raw_op;
  logic [plctmr_pkg::KIND_W-1:0] raw_kind;

  assign raw_op   = tuser_i[plctmr_pkg::OP_W-1:0];
  assign raw_kind = tuser_i[plctmr_pkg::TUSER_IN_W-1:plctmr_pkg::OP_W];

  always_comb begin
    unique case (raw_op)
      plctmr_pkg::OPC_TICK:  cmd_o.op = plctmr_pkg::OP_TICK;
      plctmr_pkg::OPC_RUN:   cmd_o.op = plctmr_pkg::OP_RUN;
      plctmr_pkg::OPC_READ:  cmd_o.op = plctmr_pkg::OP_READ;
      plctmr_pkg::OPC_WRITE: cmd_o.op = plctmr_pkg::OP_WRITE;
      plctmr_pkg::OPC_LOAD:  cmd_o.op = plctmr_pkg::OP_LOAD;
      default:               cmd_o.op = plctmr_pkg::OP_NOP;
    endcase
    unique case (raw_kind)
      plctmr_pkg::KC_X: cmd_o.kind = plctmr_pkg::KIND_X;
      plctmr_pkg::KC_Y: cmd_o.kind = plctmr_pkg::KIND_Y;
      plctmr_pkg::KC_M: cmd_o.kind = plctmr_pkg::KIND_M;
      plctmr_pkg::KC_T: cmd_o.kind = plctmr_pkg::KIND_T;
      default:          cmd_o.kind = plctmr_pkg::KIND_NONE;
    endcase
    cmd_o.idx    = tdata_i[plctmr_pkg::TD_IDX_LSB +: plctmr_pkg::IDX_W];
    cmd_o.run_en = tdata_i[plctmr_pkg::TD_EN_LSB];
    cmd_o.preset = tdata_i[plctmr_pkg::TD_PRESET_LSB +: plctmr_pkg::CNT_W];
    cmd_o.wr_val = tdata_i[plctmr_pkg::TD_WV_LSB];
    cmd_o.port   = tdata_i[plctmr_pkg::TD_PORT_LSB +: plctmr_pkg::NUM_INPUT_BITS];
  end

endmodule

FILE: design/plctmr_queue.sv
module plctmr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  plctmr_pkg::cmd_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output plctmr_pkg::cmd_t data_o
);

  plctmr_pkg::cmd_t                mem_q [plctmr_pkg::QDEPTH];
  logic [plctmr_pkg::Q_AW-1:0]     wp_q, rp_q;
  logic [plctmr_pkg::Q_CW-1:0]     cnt_q;

  assign full_o  = (cnt_q == plctmr_pkg::Q_CW'(plctmr_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/plctmr_back.sv
`include "plc_timer_bank_bit_store_assert.svh"

module plctmr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plctmr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plctmr_pkg::BOUND_W-1:0]      cfg_data_i,
  input  logic                                q_valid_i,
  input  plctmr_pkg::cmd_t                    q_cmd_i,
  output logic                                q_pop_o,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic                                bit_o,
  output logic [plctmr_pkg::PORT_W-1:0]       port_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  localparam logic [plctmr_pkg::CMP_W-1:0] NT_C =
    plctmr_pkg::CMP_W'(plctmr_pkg::NUM_TIMERS);

  state_e                                    state_q;
  logic [plctmr_pkg::TMR_IW:0]               sweep_q;
  logic [plctmr_pkg::BOUND_W-1:0]            fast_q, mid_q, slow_q;
  logic [plctmr_pkg::DIV_W-1:0]              ten_q, hund_q;
  logic                                      mid_due_q, slow_due_q;
  logic [plctmr_pkg::NUM_INPUT_BITS-1:0]     x_q;
  logic [plctmr_pkg::NUM_OUTPUT_BITS-1:0]    y_q, y_d;
  logic [plctmr_pkg::NUM_MARKER_BITS-1:0]    m_q;
  logic [plctmr_pkg::NUM_TIMERS-1:0]         done_q, en_q;
  logic [plctmr_pkg::CNT_W-1:0]              cnt_q [plctmr_pkg::NUM_TIMERS];
  logic [plctmr_pkg::CNT_W-1:0]              pre_q [plctmr_pkg::NUM_TIMERS];
  logic                                      out_valid_q, out_bit_q;
  logic [plctmr_pkg::PORT_W-1:0]             out_port_q;

  plctmr_pkg::cmd_t                          cmd;
  logic                                      slot_free, pop, sweep_last, res_load;
  logic [plctmr_pkg::CMP_W-1:0]              idx_ext, sw, fb, mb, sb;
  logic                                      tmr_ok, out_ok, mrk_ok, in_ok;
  logic [plctmr_pkg::TMR_IW-1:0]             tmr_sel, rd_idx;
  logic [plctmr_pkg::CNT_W-1:0]              cur_cnt, cur_pre, c1, c2;
  logic                                      cur_ge, c1_ge;
  logic                                      in_fast, in_mid, in_slow, sw_hit, sw_two;
  logic                                      rd_bit, res_bit, start;
  logic                                      cnt_we, pre_we;
  logic [plctmr_pkg::CNT_W-1:0]              cnt_wd;

  assign cmd        = q_cmd_i;
  assign slot_free  = !out_valid_q || m_ready_i;
  assign pop        = (state_q == ST_IDLE) && q_valid_i && slot_free;
  assign q_pop_o    = pop;
  assign sweep_last = (sweep_q == (plctmr_pkg::TMR_IW + 1)'(plctmr_pkg::NUM_TIMERS - 1));
  assign res_load   = (pop && (cmd.op != plctmr_pkg::OP_TICK)) ||
                      ((state_q == ST_DONE) && slot_free);

  assign idx_ext = {1'b0, cmd.idx};
  assign tmr_ok  = idx_ext < NT_C;
  assign out_ok  = idx_ext < plctmr_pkg::CMP_W'(plctmr_pkg::NUM_OUTPUT_BITS);
  assign mrk_ok  = idx_ext < plctmr_pkg::CMP_W'(plctmr_pkg::NUM_MARKER_BITS);
  assign in_ok   = idx_ext < plctmr_pkg::CMP_W'(plctmr_pkg::NUM_INPUT_BITS);
  assign tmr_sel = cmd.idx[plctmr_pkg::TMR_IW-1:0];
  assign rd_idx  = (state_q == ST_SWEEP) ? sweep_q[plctmr_pkg::TMR_IW-1:0] : tmr_sel;

  assign cur_cnt = cnt_q[rd_idx];
  assign cur_pre = pre_q[rd_idx];
  assign cur_ge  = cur_cnt >= cur_pre;
  assign c1      = (cur_cnt == plctmr_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign c2      = (c1 == plctmr_pkg::COUNT_MAX) ? c1 : c1 + 1'b1;
  assign c1_ge   = c1 >= cur_pre;

  assign fb = ({1'b0, fast_q} > NT_C) ? NT_C : {1'b0, fast_q};
  assign mb = ({1'b0, mid_q} > NT_C) ? NT_C : {1'b0, mid_q};
  assign sb = ({1'b0, slow_q} > NT_C) ? NT_C : {1'b0, slow_q};
  assign sw = plctmr_pkg::CMP_W'(sweep_q);

  // A timer in both the fast and the slow group advances twice.
  assign in_fast = sw < fb;
  assign in_mid  = mid_due_q && (sw >= fb) && (sw < mb);
  assign in_slow = slow_due_q && (sw >= mb) && (sw < sb);
  assign sw_hit  = en_q[rd_idx] && (in_fast || in_mid || in_slow);
  assign sw_two  = in_fast && in_slow;

  assign start = pop && (cmd.op == plctmr_pkg::OP_RUN) && tmr_ok && cmd.run_en &&
                 !en_q[tmr_sel];

  always_comb begin
    unique case (cmd.kind)
      plctmr_pkg::KIND_X:    rd_bit = in_ok && x_q[cmd.idx[plctmr_pkg::IN_IW-1:0]];
      plctmr_pkg::KIND_Y:    rd_bit = out_ok && y_q[cmd.idx[plctmr_pkg::OUT_IW-1:0]];
      plctmr_pkg::KIND_M:    rd_bit = mrk_ok && m_q[cmd.idx[plctmr_pkg::MRK_IW-1:0]];
      plctmr_pkg::KIND_T:    rd_bit = tmr_ok && done_q[tmr_sel];
      plctmr_pkg::KIND_NONE: rd_bit = 1'b0;
      default:               rd_bit = 1'b0;
    endcase
    unique case (cmd.op)
      plctmr_pkg::OP_RUN:  res_bit = tmr_ok && cmd.run_en && en_q[tmr_sel] && cur_ge;
      plctmr_pkg::OP_READ: res_bit = rd_bit;
      default:             res_bit = 1'b0;
    endcase
    y_d = y_q;
    if (pop && (cmd.op == plctmr_pkg::OP_WRITE) && (cmd.kind == plctmr_pkg::KIND_Y) &&
        out_ok) begin
      y_d[cmd.idx[plctmr_pkg::OUT_IW-1:0]] = cmd.wr_val;
    end
    cnt_we = 1'b0;
    cnt_wd = c1;
    pre_we = 1'b0;
    if (state_q == ST_SWEEP) begin
      cnt_we = sw_hit;
      cnt_wd = sw_two ? c2 : c1;
    end else if (start) begin
      cnt_we = 1'b1;
      cnt_wd = '0;
      pre_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_q[rd_idx] <= cnt_wd;
    end
    if (pre_we) begin
      pre_q[rd_idx] <= cmd.preset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_q     <= '0;
      fast_q      <= plctmr_pkg::FAST_END_RST;
      mid_q       <= plctmr_pkg::MID_END_RST;
      slow_q      <= plctmr_pkg::SLOW_END_RST;
      ten_q       <= '0;
      hund_q      <= '0;
      mid_due_q   <= 1'b0;
      slow_due_q  <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      m_q         <= '0;
      done_q      <= '0;
      en_q        <= '0;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
      out_port_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          plctmr_pkg::CFG_FAST_END: fast_q <= cfg_data_i;
          plctmr_pkg::CFG_MID_END:  mid_q  <= cfg_data_i;
          plctmr_pkg::CFG_SLOW_END: slow_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      y_q <= y_d;
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (cmd.op == plctmr_pkg::OP_TICK) begin
              state_q    <= ST_SWEEP;
              sweep_q    <= '0;
              mid_due_q  <= (ten_q == plctmr_pkg::DIV_LAST);
              slow_due_q <= (ten_q == plctmr_pkg::DIV_LAST) &&
                            (hund_q == plctmr_pkg::DIV_LAST);
              if (ten_q == plctmr_pkg::DIV_LAST) begin
                ten_q  <= '0;
                hund_q <= (hund_q == plctmr_pkg::DIV_LAST) ? '0 : hund_q + 1'b1;
              end else begin
                ten_q <= ten_q + 1'b1;
              end
            end else begin
              out_bit_q   <= res_bit;
              out_port_q  <= y_d[plctmr_pkg::PORT_W-1:0];
            end
            unique case (cmd.op)
              plctmr_pkg::OP_RUN: begin
                if (tmr_ok) begin
                  if (!cmd.run_en) begin
                    en_q[tmr_sel]   <= 1'b0;
                    done_q[tmr_sel] <= 1'b0;
                  end else if (!en_q[tmr_sel]) begin
                    en_q[tmr_sel]   <= 1'b1;
                    done_q[tmr_sel] <= 1'b0;
                  end
                end
              end
              plctmr_pkg::OP_WRITE: begin
                if ((cmd.kind == plctmr_pkg::KIND_M) && mrk_ok) begin
                  m_q[cmd.idx[plctmr_pkg::MRK_IW-1:0]] <= cmd.wr_val;
                end
              end
              plctmr_pkg::OP_LOAD: x_q <= cmd.port;
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          if (sw_hit) begin
            done_q[rd_idx] <= sw_two ? c1_ge : cur_ge;
          end
          if (sweep_last) begin
            state_q <= ST_DONE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_bit_q   <= 1'b0;
            out_port_q  <= y_q[plctmr_pkg::PORT_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_valid_o = out_valid_q;
  assign bit_o     = out_bit_q;
  assign port_o    = out_port_q;

  `PLC_ASSERT(a_done_needs_en, clk_i, rst_ni, (done_q & ~en_q) == '0)
  `PLC_ASSERT(a_ten_range, clk_i, rst_ni, ten_q <= plctmr_pkg::DIV_LAST)
  `PLC_ASSERT(a_hund_range, clk_i, rst_ni, hund_q <= plctmr_pkg::DIV_LAST)
  `PLC_ASSERT_NEXT(a_sweep_end, clk_i, rst_ni, sweep_last && state_q == ST_SWEEP, state_q == ST_DONE)
  `PLC_ASSERT_NEXT(a_emit, clk_i, rst_ni, pop && (cmd.op != plctmr_pkg::OP_TICK), out_valid_q)

endmodule

FILE: design/plc_timer_bank_bit_store.sv
// A read, write, timer run or port load shows its result in the output register; a tick
// sweeps all NUM_TIMERS timers in the back end, then emits a result. One timer
// entry is visited per cycle through the single count/preset read port.
// Other items sustain one per cycle while no tick runs and output is taken; a 2-entry
// queue decouples input and result. Reset (rst_ni low, asynchronous): all stores, timer
// enables, done bits, tick dividers clear; group bounds reset to 8, 16, 32; ready at once.
module plc_timer_bank_bit_store (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // bit_index, run_enable, preset, write_value, port_word, zero fill
  input  logic [plctmr_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // operation, register_kind
  input  logic [plctmr_pkg::TUSER_IN_W-1:0]    s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // bit_value, output_port, zero fill
  output logic [plctmr_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [plctmr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [plctmr_pkg::BOUND_W-1:0]       cfg_data_i
);

  plctmr_pkg::cmd_t              in_cmd, q_cmd;
  logic                          q_full, q_valid, q_pop, push;
  logic                          res_bit;
  logic [plctmr_pkg::PORT_W-1:0] res_port;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  plctmr_front u_front (
    .tdata_i (s_axis_tdata),
    .tuser_i (s_axis_tuser),
    .cmd_o   (in_cmd)
  );

  plctmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  plctmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .bit_o       (res_bit),
    .port_o      (res_port)
  );

  assign m_axis_tdata = {{(plctmr_pkg::TDATA_OUT_W - 1 - plctmr_pkg::PORT_W){1'b0}},
                         res_port, res_bit};

endmodule
